// ===== src/fit_pkg.sv =====
`timescale 1ns / 1ps

package fit_pkg;

    // table geometry
    localparam int TABLE_ENTRIES = 128;
    localparam int ADDR_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

    // field widths
    localparam int WORD_W = 32;
    localparam int KEY_W = 3 * WORD_W;
    localparam int ID_W = 8;

    typedef logic [KEY_W-1:0] key_t;
    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [CNT_W-1:0] count_t;
    typedef logic [ID_W-1:0] ident_t;
    typedef logic [WORD_W-1:0] word_t;

    // access request from the search control to the key store
    typedef struct packed {
        logic  rd_en;
        addr_t rd_addr;
        logic  wr_en;
        addr_t wr_addr;
        key_t  wr_key;
    } mem_req_t;

    // finished result handed to the output stage
    typedef struct packed {
        ident_t identity;
        word_t  device_id;
    } result_t;

    // position count to identity, wrapping to the identity width
    function automatic ident_t to_identity(input count_t c);
        logic [CNT_W+ID_W-1:0] w;
        begin
            w = {{ID_W{1'b0}}, c};
            return w[ID_W-1:0];
        end
    endfunction

endpackage

// ===== src/fit_key_store.sv =====
`timescale 1ns / 1ps

module fit_key_store
    import fit_pkg::*;
(
    input  logic     clk,
    input  mem_req_t req,
    output key_t     rd_data
);

    key_t mem [TABLE_ENTRIES];
    key_t rd_data_reg;

    // single write port
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_key;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== src/fit_search_ctrl.sv =====
`timescale 1ns / 1ps

module fit_search_ctrl
    import fit_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    // request side
    input  logic     req_valid,
    output logic     req_ready,
    input  logic     req_info_valid,
    input  key_t     req_key,
    // key store
    output mem_req_t mem_req,
    input  key_t     mem_rd_data,
    // result side
    output logic     res_valid,
    input  logic     res_ready,
    output result_t  res
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SEARCH = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0] state_reg, state_next;
    count_t fill_count_reg, fill_count_next;
    count_t rd_idx_reg, rd_idx_next;
    logic cmp_valid_reg, cmp_valid_next;
    addr_t cmp_idx_reg, cmp_idx_next;
    key_t key_reg, key_next;
    result_t res_reg, res_next;

    logic match;
    logic more_reads;
    word_t key_vol;
    word_t dev_val;

    assign key_vol = key_reg[WORD_W-1:0];
    assign dev_val = (key_vol == '0) ? word_t'(1) : key_vol;
    assign match = cmp_valid_reg && (mem_rd_data == key_reg);
    assign more_reads = (rd_idx_reg < fill_count_reg);

    assign req_ready = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_DONE);
    assign res = res_reg;

    // search sequencer: one read issued and one compare per cycle
    always_comb
    begin
        state_next = state_reg;
        fill_count_next = fill_count_reg;
        rd_idx_next = rd_idx_reg;
        cmp_valid_next = 1'b0;
        cmp_idx_next = cmp_idx_reg;
        key_next = key_reg;
        res_next = res_reg;
        mem_req = '0;
        mem_req.wr_key = key_reg;
        mem_req.wr_addr = fill_count_reg[ADDR_W-1:0];
        mem_req.rd_addr = rd_idx_reg[ADDR_W-1:0];

        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    key_next = req_key;
                    rd_idx_next = '0;
                    if (req_info_valid)
                    begin
                        state_next = ST_SEARCH;
                    end
                    else
                    begin
                        res_next.identity = '0;
                        res_next.device_id = word_t'(1);
                        state_next = ST_DONE;
                    end
                end
            end
            ST_SEARCH:
            begin
                if (match)
                begin
                    // hit at the compared position
                    res_next.identity = to_identity(CNT_W'(cmp_idx_reg) + CNT_W'(1));
                    res_next.device_id = dev_val;
                    state_next = ST_DONE;
                end
                else if (more_reads)
                begin
                    mem_req.rd_en = 1'b1;
                    rd_idx_next = rd_idx_reg + CNT_W'(1);
                    cmp_valid_next = 1'b1;
                    cmp_idx_next = rd_idx_reg[ADDR_W-1:0];
                end
                else if (!cmp_valid_reg)
                begin
                    // miss: append when there is room
                    if (fill_count_reg < CNT_W'(TABLE_ENTRIES))
                    begin
                        mem_req.wr_en = 1'b1;
                        fill_count_next = fill_count_reg + CNT_W'(1);
                        res_next.identity = to_identity(fill_count_reg + CNT_W'(1));
                        res_next.device_id = dev_val;
                    end
                    else
                    begin
                        res_next.identity = '0;
                        res_next.device_id = word_t'(1);
                    end
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            fill_count_reg <= '0;
            cmp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fill_count_reg <= fill_count_next;
            cmp_valid_reg <= cmp_valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        rd_idx_reg <= rd_idx_next;
        cmp_idx_reg <= cmp_idx_next;
        key_reg <= key_next;
        res_reg <= res_next;
    end

    // fill count stays within the table
    assert property (@(posedge clk) disable iff (!rst_n)
        fill_count_reg <= CNT_W'(TABLE_ENTRIES))
        else $error("fill count beyond table size");

    // an append grows the fill count by exactly one
    assert property (@(posedge clk) disable iff (!rst_n)
        mem_req.wr_en |=> fill_count_reg == $past(fill_count_reg) + CNT_W'(1))
        else $error("append without fill count step");

    // no append while a read is still in flight
    assert property (@(posedge clk) disable iff (!rst_n)
        mem_req.wr_en |-> !cmp_valid_reg && !mem_req.rd_en)
        else $error("append overlaps search read");

    // no identity means device one
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (res.identity == '0) |-> res.device_id == word_t'(1))
        else $error("device id not one for empty identity");

endmodule

// ===== src/file_identity_table_unit.sv =====
`timescale 1ns / 1ps

// File identity table: each request carries a 96-bit key (volume serial,
// index high, index low) and an info-valid flag in tuser. The key is looked
// up in a table of up to 128 stored keys; a hit returns position plus one,
// a miss appends the key and returns its new position plus one, or 0 when
// the table is full. An invalid request returns 0. device_id is the volume
// serial, or 1 when the serial is zero or the identity is 0. The search reads
// the key memory (one write port, one registered read port) one entry per
// cycle; one request is searched at a time, and the next one is taken while
// the previous result still waits in the output register.
module file_identity_table_unit
    import fit_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,   // volume_serial, index_high, index_low
    input  logic        s_tuser,   // info_valid
    // output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // identity, device_id
);

    mem_req_t mem_req;
    key_t mem_rd_data;
    logic res_valid;
    logic res_ready;
    result_t res;

    logic m_tvalid_reg;
    result_t out_reg;

    fit_search_ctrl u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_valid      (s_tvalid),
        .req_ready      (s_tready),
        .req_info_valid (s_tuser),
        .req_key        (s_tdata),
        .mem_req        (mem_req),
        .mem_rd_data    (mem_rd_data),
        .res_valid      (res_valid),
        .res_ready      (res_ready),
        .res            (res)
    );

    fit_key_store u_store (
        .clk     (clk),
        .req     (mem_req),
        .rd_data (mem_rd_data)
    );

    // output register, free when empty or being drained
    assign res_ready = !m_tvalid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            m_tvalid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            out_reg <= res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata = {out_reg.device_id, out_reg.identity};

endmodule
